// File: rtl/two_mass_feedforward_force_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-mass feedforward force unit
// Concurrent checks clocked on clk; one form honors reset, one does not.
// ----------------------------------------------------------------------------
`ifndef TWO_MASS_FEEDFORWARD_FORCE_UNIT_ASSERT_SVH
`define TWO_MASS_FEEDFORWARD_FORCE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define TMFF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TMFF_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TMFF_ASSERT(lbl, prop, msg)
`define TMFF_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// File: rtl/tmff_pkg.sv
// ----------------------------------------------------------------------------
// tmff_pkg
// Shared widths, register indexes, reset values, command types and clamping.
// ----------------------------------------------------------------------------
package tmff_pkg;

	localparam int DATA_W        = 32;
	localparam int TS_W          = 31;
	localparam int CFG_IDX_W     = 3;
	localparam int FRAC_BITS_DEF = 16;
	localparam int MUL_SEL_W     = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MASS_ONE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DAMPING      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS_ONE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FORCE_SHARE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = 3'd5;

	localparam logic signed [DATA_W-1:0] RST_MASS_ONE     = 32'sd65536;
	localparam logic signed [DATA_W-1:0] RST_DAMPING      = 32'sd0;
	localparam logic signed [DATA_W-1:0] RST_STIFFNESS    = 32'sd0;
	localparam logic signed [DATA_W-1:0] RST_INV_MASS_ONE = 32'sd65536;
	localparam logic signed [DATA_W-1:0] RST_FORCE_SHARE  = 32'sd32768;
	localparam logic [TS_W-1:0]          RST_TIME_STEP    = 31'd655;

	// multiplier operand pairs; the product lands in the matching register
	localparam logic [MUL_SEL_W-1:0] MUL_MA  = 3'd0; // m1 * a
	localparam logic [MUL_SEL_W-1:0] MUL_DV  = 3'd1; // d * v
	localparam logic [MUL_SEL_W-1:0] MUL_KP  = 3'd2; // k * p
	localparam logic [MUL_SEL_W-1:0] MUL_PV  = 3'd3; // v * dt
	localparam logic [MUL_SEL_W-1:0] MUL_U   = 3'd4; // num * share
	localparam logic [MUL_SEL_W-1:0] MUL_DVR = 3'd5; // acc * 1/m1
	localparam logic [MUL_SEL_W-1:0] MUL_VV  = 3'd6; // dv_rate * dt

	typedef struct packed {
		logic                 start;   // capture accel, clear flag
		logic                 load;    // take initial position and velocity
		logic                 mul_go;
		logic [MUL_SEL_W-1:0] mul_sel;
		logic                 sum_go;
		logic                 sum_acc; // 0: force numerator, 1: mass-one accel
		logic                 update;  // commit state, load output register
	} cmd_t;

	typedef struct packed {
		logic out_stall;
	} sts_t;

	// bit 32 flags a clamp, bits 31:0 hold the clamped value
	function automatic logic [DATA_W:0] clamp64(input logic signed [63:0] x);
		if (x[63:DATA_W-1] != {(65-DATA_W){x[63]}})
			return {1'b1, x[63], {(DATA_W-1){~x[63]}}};
		return {1'b0, x[DATA_W-1:0]};
	endfunction

endpackage

// File: rtl/tmff_ctrl.sv
// ----------------------------------------------------------------------------
// tmff_ctrl
// Sequencer: walks one step item through the shared multiplier and adder.
// ----------------------------------------------------------------------------
`include "two_mass_feedforward_force_unit_assert.svh"

module tmff_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                mode,
	input  tmff_pkg::sts_t      sts,
	output logic                s_tready,
	output tmff_pkg::cmd_t      cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MA   = 4'd1;
	localparam logic [3:0] ST_DV   = 4'd2;
	localparam logic [3:0] ST_KP   = 4'd3;
	localparam logic [3:0] ST_PV   = 4'd4;
	localparam logic [3:0] ST_NUM  = 4'd5;
	localparam logic [3:0] ST_U    = 4'd6;
	localparam logic [3:0] ST_WU   = 4'd7;
	localparam logic [3:0] ST_ACC  = 4'd8;
	localparam logic [3:0] ST_DVR  = 4'd9;
	localparam logic [3:0] ST_WDVR = 4'd10;
	localparam logic [3:0] ST_VV   = 4'd11;
	localparam logic [3:0] ST_WVV  = 4'd12;
	localparam logic [3:0] ST_UPD  = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = tmff_pkg::MUL_MA;
		case (state_q)
			ST_IDLE: begin
				cmd.load  = accept & ~mode;
				cmd.start = accept & mode;
				if (accept && mode)
					state_d = ST_MA;
			end
			ST_MA: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = tmff_pkg::MUL_MA;
				state_d     = ST_DV;
			end
			ST_DV: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = tmff_pkg::MUL_DV;
				state_d     = ST_KP;
			end
			ST_KP: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = tmff_pkg::MUL_KP;
				state_d     = ST_PV;
			end
			ST_PV: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = tmff_pkg::MUL_PV;
				state_d     = ST_NUM;
			end
			ST_NUM: begin
				cmd.sum_go = 1'b1;
				state_d    = ST_U;
			end
			ST_U: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = tmff_pkg::MUL_U;
				state_d     = ST_WU;
			end
			ST_WU: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.sum_go  = 1'b1;
				cmd.sum_acc = 1'b1;
				state_d     = ST_DVR;
			end
			ST_DVR: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = tmff_pkg::MUL_DVR;
				state_d     = ST_WDVR;
			end
			ST_WDVR: begin
				state_d = ST_VV;
			end
			ST_VV: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = tmff_pkg::MUL_VV;
				state_d     = ST_WVV;
			end
			ST_WVV: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				// hold until the output register can take the item
				if (!sts.out_stall) begin
					cmd.update = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	`TMFF_ASSERT(a_step_starts, (accept && mode) |=> (state_q == ST_MA), "step did not start")
	`TMFF_ASSERT(a_load_idle, (accept && !mode) |=> (state_q == ST_IDLE), "load left idle")
	`TMFF_ASSERT(a_upd_done, cmd.update |=> (state_q == ST_IDLE), "update did not finish")
	`TMFF_ASSERT_NR(a_rst_idle, !arst_n |=> (state_q == ST_IDLE), "state not idle in reset")

endmodule

// File: rtl/tmff_dp.sv
// ----------------------------------------------------------------------------
// tmff_dp
// Datapath: configuration registers, shared 32x32 multiplier with floor
// shift and clamp, shared adder, position and velocity state, output register.
// ----------------------------------------------------------------------------
module tmff_dp #(
	parameter int FRAC_BITS = tmff_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [tmff_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tmff_pkg::DATA_W-1:0]          cfg_data,
	input  logic signed [tmff_pkg::DATA_W-1:0]   accel,
	input  logic signed [tmff_pkg::DATA_W-1:0]   init_pos,
	input  logic signed [tmff_pkg::DATA_W-1:0]   init_vel,
	input  tmff_pkg::cmd_t                       cmd,
	output tmff_pkg::sts_t                       sts,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic signed [tmff_pkg::DATA_W-1:0]   force_res,
	output logic                                 saturated
);

	localparam int W = tmff_pkg::DATA_W;

	logic signed [W-1:0]                   mass_one_q, damping_q, stiffness_q;
	logic signed [W-1:0]                   inv_mass_one_q, force_share_q;
	logic [tmff_pkg::TS_W-1:0]             time_step_q;

	logic signed [W-1:0]                   p_q, v_q, a_q;
	logic signed [W-1:0]                   t_ma_q, t_dv_q, t_kp_q, pv_q;
	logic signed [W-1:0]                   num_q, u_q, acc_q, dvr_q, vdt_q;
	logic                                  sat_q;

	logic signed [W-1:0]                   opa, opb;
	logic signed [2*W-1:0]                 prod_s1;
	logic [tmff_pkg::MUL_SEL_W-1:0]        sel_s1;
	logic                                  pend_s1;
	logic signed [2*W-1:0]                 shifted;
	logic [W:0]                            wb_c;

	logic signed [W+1:0]                   third, sum34;
	logic [W:0]                            sum_c;
	logic signed [W:0]                     np33, nv33;
	logic [W:0]                            np_c, nv_c;

	logic                                  m_tvalid_q;
	logic signed [W-1:0]                   force_res_q;
	logic                                  sat_out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_one_q     <= tmff_pkg::RST_MASS_ONE;
			damping_q      <= tmff_pkg::RST_DAMPING;
			stiffness_q    <= tmff_pkg::RST_STIFFNESS;
			inv_mass_one_q <= tmff_pkg::RST_INV_MASS_ONE;
			force_share_q  <= tmff_pkg::RST_FORCE_SHARE;
			time_step_q    <= tmff_pkg::RST_TIME_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				tmff_pkg::CFG_MASS_ONE:     mass_one_q     <= cfg_data;
				tmff_pkg::CFG_DAMPING:      damping_q      <= cfg_data;
				tmff_pkg::CFG_STIFFNESS:    stiffness_q    <= cfg_data;
				tmff_pkg::CFG_INV_MASS_ONE: inv_mass_one_q <= cfg_data;
				tmff_pkg::CFG_FORCE_SHARE:  force_share_q  <= cfg_data;
				tmff_pkg::CFG_TIME_STEP:    time_step_q    <= cfg_data[tmff_pkg::TS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// multiplier operand select
	always_comb begin
		case (cmd.mul_sel)
			tmff_pkg::MUL_MA:  begin opa = mass_one_q;  opb = a_q;            end
			tmff_pkg::MUL_DV:  begin opa = damping_q;   opb = v_q;            end
			tmff_pkg::MUL_KP:  begin opa = stiffness_q; opb = p_q;            end
			tmff_pkg::MUL_PV:  begin opa = v_q;         opb = {1'b0, time_step_q}; end
			tmff_pkg::MUL_U:   begin opa = num_q;       opb = force_share_q;  end
			tmff_pkg::MUL_DVR: begin opa = acc_q;       opb = inv_mass_one_q; end
			tmff_pkg::MUL_VV:  begin opa = dvr_q;       opb = {1'b0, time_step_q}; end
			default:           begin opa = mass_one_q;  opb = a_q;            end
		endcase
	end

	// arithmetic shift floors toward minus infinity
	assign shifted = prod_s1 >>> FRAC_BITS;
	assign wb_c    = tmff_pkg::clamp64(shifted);

	assign third = cmd.sum_acc ? -{{2{u_q[W-1]}}, u_q} : {{2{t_ma_q[W-1]}}, t_ma_q};
	assign sum34 = third - {{2{t_dv_q[W-1]}}, t_dv_q} - {{2{t_kp_q[W-1]}}, t_kp_q};
	assign sum_c = tmff_pkg::clamp64({{(62-W){sum34[W+1]}}, sum34});

	assign np33 = {p_q[W-1], p_q} + {pv_q[W-1], pv_q};
	assign nv33 = {v_q[W-1], v_q} + {vdt_q[W-1], vdt_q};
	assign np_c = tmff_pkg::clamp64({{(63-W){np33[W]}}, np33});
	assign nv_c = tmff_pkg::clamp64({{(63-W){nv33[W]}}, nv33});

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			prod_s1 <= opa * opb;
			sel_s1  <= cmd.mul_sel;
		end
		if (cmd.start)
			a_q <= accel;
		if (pend_s1) begin
			case (sel_s1)
				tmff_pkg::MUL_MA:  t_ma_q <= wb_c[W-1:0];
				tmff_pkg::MUL_DV:  t_dv_q <= wb_c[W-1:0];
				tmff_pkg::MUL_KP:  t_kp_q <= wb_c[W-1:0];
				tmff_pkg::MUL_PV:  pv_q   <= wb_c[W-1:0];
				tmff_pkg::MUL_U:   u_q    <= wb_c[W-1:0];
				tmff_pkg::MUL_DVR: dvr_q  <= wb_c[W-1:0];
				tmff_pkg::MUL_VV:  vdt_q  <= wb_c[W-1:0];
				default: begin
				end
			endcase
		end
		if (cmd.sum_go) begin
			if (cmd.sum_acc)
				acc_q <= sum_c[W-1:0];
			else
				num_q <= sum_c[W-1:0];
		end
		if (cmd.update) begin
			force_res_q <= u_q;
			sat_out_q   <= sat_q | np_c[W] | nv_c[W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q        <= '0;
			v_q        <= '0;
			sat_q      <= 1'b0;
			pend_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			pend_s1 <= cmd.mul_go;
			if (cmd.start)
				sat_q <= 1'b0;
			else
				sat_q <= sat_q | (pend_s1 & wb_c[W]) | (cmd.sum_go & sum_c[W]);
			if (cmd.load) begin
				p_q <= init_pos;
				v_q <= init_vel;
			end else if (cmd.update) begin
				p_q <= np_c[W-1:0];
				v_q <= nv_c[W-1:0];
			end
			if (cmd.update)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	assign sts.out_stall = m_tvalid_q & ~m_tready;
	assign m_tvalid      = m_tvalid_q;
	assign force_res     = force_res_q;
	assign saturated     = sat_out_q;

endmodule

// File: rtl/two_mass_feedforward_force_unit.sv
// ----------------------------------------------------------------------------
// two_mass_feedforward_force_unit
// Step item: no new item is taken until the update state loads the result
// into the output register, and that update waits while the output is
// stalled. The pace is set by seven products through one shared 32x32
// multiplier with a registered product, four of them in a dependent chain.
// Load item: takes initial position and velocity, no result. Reset restores
// register defaults and clears position, velocity and output valid at once.
// ----------------------------------------------------------------------------
module two_mass_feedforward_force_unit #(
	parameter int FRAC_BITS = tmff_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [3*tmff_pkg::DATA_W-1:0]       s_tdata,  // accel, init_pos, init_vel
	input  logic [0:0]                          s_tuser,  // mode
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tmff_pkg::DATA_W-1:0]         m_tdata,  // force_res
	output logic [0:0]                          m_tuser,  // saturated
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tmff_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tmff_pkg::DATA_W-1:0]         cfg_data
);

	localparam int W = tmff_pkg::DATA_W;

	tmff_pkg::cmd_t       cmd;
	tmff_pkg::sts_t       sts;
	logic signed [W-1:0]  force_res;
	logic                 saturated;

	assign cfg_ready = 1'b1;

	tmff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.mode     (s_tuser[0]),
		.sts      (sts),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	tmff_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accel     (s_tdata[W-1:0]),
		.init_pos  (s_tdata[2*W-1:W]),
		.init_vel  (s_tdata[3*W-1:2*W]),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.force_res (force_res),
		.saturated (saturated)
	);

	assign m_tdata    = force_res;
	assign m_tuser[0] = saturated;

endmodule
